// File: design/c2p_pkg.sv
// c2p_pkg: shared types and constants of the cartesian to polar converter
// region codes, fixed-point formats, gain constant and arctangent table
// no dependencies
package c2p_pkg;

  localparam int GUARD     = 16;  // extra fraction bits in the rotation datapath
  localparam int GAIN_FRAC = 24;  // fraction bits of the inverse gain
  localparam int ZW        = 28;  // angle accumulator width, degrees * 2^20
  localparam int TABLE_LEN = 24;
  localparam int ANGLE_W   = 16;
  localparam int AMAG_W    = 14;  // folded angle 0..90 degrees * 128
  localparam int Z_SHIFT   = 13;  // 2^20 -> 2^7 scaling of the angle

  localparam logic [GAIN_FRAC-1:0] INV_GAIN = 24'd10188014;
  localparam logic [ZW-1:0]        Z_ROUND  = 28'd4096;

  localparam logic [ANGLE_W-1:0] DEG0   = 16'd0;
  localparam logic [ANGLE_W-1:0] DEG90  = 16'd11520;
  localparam logic [ANGLE_W-1:0] DEG180 = 16'd23040;
  localparam logic [ANGLE_W-1:0] DEG270 = 16'd34560;
  localparam logic [ANGLE_W-1:0] DEG360 = 16'd46080;

  typedef enum logic [2:0] {
    REG_ORIGIN = 3'd0,
    REG_Q1     = 3'd1,
    REG_Q2     = 3'd2,
    REG_Q3     = 3'd3,
    REG_Q4     = 3'd4,
    REG_Y_AXIS = 3'd5,
    REG_X_AXIS = 3'd6
  } region_e;

  // travels beside the datapath: region and sign of the axis coordinate
  typedef struct packed {
    region_e region;
    logic    neg;
  } side_t;

  // arctangent of 2^-idx in degrees * 2^20, rounded to nearest
  function automatic logic [ZW-1:0] atan_deg_q20(input int unsigned idx);
    case (idx)
      0:       return 28'd47185920;
      1:       return 28'd27855475;
      2:       return 28'd14718068;
      3:       return 28'd7471121;
      4:       return 28'd3750058;
      5:       return 28'd1876857;
      6:       return 28'd938658;
      7:       return 28'd469357;
      8:       return 28'd234682;
      9:       return 28'd117342;
      10:      return 28'd58671;
      11:      return 28'd29335;
      12:      return 28'd14668;
      13:      return 28'd7334;
      14:      return 28'd3667;
      15:      return 28'd1833;
      16:      return 28'd917;
      17:      return 28'd458;
      18:      return 28'd229;
      19:      return 28'd115;
      20:      return 28'd57;
      21:      return 28'd29;
      22:      return 28'd14;
      23:      return 28'd7;
      default: return '0;
    endcase
  endfunction

endpackage

// File: design/c2p_if.sv
// c2p_if: valid/ready channels of the converter
// point request in, polar result out; uses no package
interface c2p_point_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_polar_if #(
  parameter int COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] radius;
  logic [15:0]            angle;
  logic [2:0]             region;

  modport source (output valid, output radius, output angle, output region, input ready);
  modport sink   (input valid, input radius, input angle, input region, output ready);
endinterface

// File: design/cartesian_to_polar.sv
// Cartesian to polar converter: takes one signed (x, y) point per cycle
// while the pipeline does not stall and returns radius, angle in 1/128
// degree and a region code. Every point passes CORDIC_STEPS + 3 register
// stages: a classify and fold stage, one stage per CORDIC vectoring
// micro-rotation, a gain correction multiply stage and the result register.
// Each stage stalls only while it holds a request that the next one cannot
// take, so empty stages close up behind a waiting result. Points on an axis
// or at the origin get exact results.
// Depends on c2p_pkg, c2p_if, c2p_prep, c2p_rot and c2p_post.
module cartesian_to_polar #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  c2p_point_if.sink     point_i,
  c2p_polar_if.source   polar_o
);

  localparam int DW = COORD_WIDTH + c2p_pkg::GUARD + 3;
  localparam int N  = CORDIC_STEPS;

  logic                          vld   [N+1];
  logic                          rdy   [N+1];
  logic signed [DW-1:0]          cx    [N+1];
  logic signed [DW-1:0]          cy    [N+1];
  logic signed [c2p_pkg::ZW-1:0] z     [N+1];
  c2p_pkg::side_t                side  [N+1];
  logic [COORD_WIDTH-1:0]        mag   [N+1];
  c2p_pkg::region_e              region;

  c2p_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .DW          (DW)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (point_i.valid),
    .ready_o   (point_i.ready),
    .x_coord_i (point_i.x_coord),
    .y_coord_i (point_i.y_coord),
    .valid_o   (vld[0]),
    .ready_i   (rdy[0]),
    .cx_o      (cx[0]),
    .cy_o      (cy[0]),
    .side_o    (side[0]),
    .mag_o     (mag[0])
  );

  assign z[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_rot
    c2p_rot #(
      .COORD_WIDTH (COORD_WIDTH),
      .DW          (DW),
      .STEP        (k)
    ) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .cx_i    (cx[k]),
      .cy_i    (cy[k]),
      .z_i     (z[k]),
      .side_i  (side[k]),
      .mag_i   (mag[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .cx_o    (cx[k+1]),
      .cy_o    (cy[k+1]),
      .z_o     (z[k+1]),
      .side_o  (side[k+1]),
      .mag_o   (mag[k+1])
    );
  end

  c2p_post #(
    .COORD_WIDTH (COORD_WIDTH),
    .DW          (DW)
  ) u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld[N]),
    .ready_o  (rdy[N]),
    .cx_i     (cx[N]),
    .z_i      (z[N]),
    .side_i   (side[N]),
    .mag_i    (mag[N]),
    .valid_o  (polar_o.valid),
    .ready_i  (polar_o.ready),
    .radius_o (polar_o.radius),
    .angle_o  (polar_o.angle),
    .region_o (region)
  );

  assign polar_o.region = region;

`ifndef SYNTH
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_o.valid && (polar_o.region == c2p_pkg::REG_ORIGIN) |->
      (polar_o.radius == '0) && (polar_o.angle == c2p_pkg::DEG0))
    else $error("origin result not zero");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_o.valid |-> (polar_o.angle < c2p_pkg::DEG360))
    else $error("angle past a full turn");

  a_x_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_o.valid && (polar_o.region == c2p_pkg::REG_X_AXIS) |->
      (polar_o.angle == c2p_pkg::DEG0) || (polar_o.angle == c2p_pkg::DEG180))
    else $error("x axis angle not exact");

  a_y_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_o.valid && (polar_o.region == c2p_pkg::REG_Y_AXIS) |->
      (polar_o.angle == c2p_pkg::DEG90) || (polar_o.angle == c2p_pkg::DEG270))
    else $error("y axis angle not exact");

  a_q1_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    polar_o.valid && (polar_o.region == c2p_pkg::REG_Q1) |->
      (polar_o.angle <= c2p_pkg::DEG90))
    else $error("first quadrant angle out of range");
`endif

endmodule

// File: design/c2p_prep.sv
// c2p_prep: first pipeline stage, classifies the point and folds it into quadrant one
// uses c2p_pkg
module c2p_prep #(
  parameter int COORD_WIDTH = 16,
  parameter int DW          = 35
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [DW-1:0]          cx_o,
  output logic signed [DW-1:0]          cy_o,
  output c2p_pkg::side_t                side_o,
  output logic [COORD_WIDTH-1:0]        mag_o
);

  localparam int PAD = DW - COORD_WIDTH - c2p_pkg::GUARD;

  logic [COORD_WIDTH-1:0] x_raw, y_raw, ax, ay;
  logic                   x_zero, y_zero, en;
  c2p_pkg::side_t         side_d, side_q;
  logic [COORD_WIDTH-1:0] mag_d, mag_q;
  logic signed [DW-1:0]   cx_d, cx_q, cy_d, cy_q;
  logic                   valid_q;

  assign x_raw  = x_coord_i;
  assign y_raw  = y_coord_i;
  // unsigned view keeps the most negative value as 2^(w-1)
  assign ax     = x_raw[COORD_WIDTH-1] ? (~x_raw + 1'b1) : x_raw;
  assign ay     = y_raw[COORD_WIDTH-1] ? (~y_raw + 1'b1) : y_raw;
  assign x_zero = (x_raw == '0);
  assign y_zero = (y_raw == '0);

  always_comb begin
    side_d.neg = x_raw[COORD_WIDTH-1];
    mag_d      = ax;
    if (x_zero && y_zero) begin
      side_d.region = c2p_pkg::REG_ORIGIN;
    end else if (x_zero) begin
      side_d.region = c2p_pkg::REG_Y_AXIS;
      side_d.neg    = y_raw[COORD_WIDTH-1];
      mag_d         = ay;
    end else if (y_zero) begin
      side_d.region = c2p_pkg::REG_X_AXIS;
    end else if (!x_raw[COORD_WIDTH-1] && !y_raw[COORD_WIDTH-1]) begin
      side_d.region = c2p_pkg::REG_Q1;
    end else if (x_raw[COORD_WIDTH-1] && !y_raw[COORD_WIDTH-1]) begin
      side_d.region = c2p_pkg::REG_Q2;
    end else if (x_raw[COORD_WIDTH-1]) begin
      side_d.region = c2p_pkg::REG_Q3;
    end else begin
      side_d.region = c2p_pkg::REG_Q4;
    end
  end

  assign cx_d = $signed({{PAD{1'b0}}, ax, {c2p_pkg::GUARD{1'b0}}});
  assign cy_d = $signed({{PAD{1'b0}}, ay, {c2p_pkg::GUARD{1'b0}}});

  assign en = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      side_q <= side_d;
      mag_q  <= mag_d;
    end
  end

  assign ready_o = en;
  assign valid_o = valid_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign side_o  = side_q;
  assign mag_o   = mag_q;

endmodule

// File: design/c2p_rot.sv
// c2p_rot: one vectoring micro-rotation as one pipeline stage
// uses c2p_pkg for the arctangent table and side-band type
module c2p_rot #(
  parameter int COORD_WIDTH = 16,
  parameter int DW          = 35,
  parameter int STEP        = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [DW-1:0]         cx_i,
  input  logic signed [DW-1:0]         cy_i,
  input  logic signed [c2p_pkg::ZW-1:0] z_i,
  input  c2p_pkg::side_t               side_i,
  input  logic [COORD_WIDTH-1:0]       mag_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [DW-1:0]         cx_o,
  output logic signed [DW-1:0]         cy_o,
  output logic signed [c2p_pkg::ZW-1:0] z_o,
  output c2p_pkg::side_t               side_o,
  output logic [COORD_WIDTH-1:0]       mag_o
);

  localparam logic signed [c2p_pkg::ZW-1:0] ATAN = $signed(c2p_pkg::atan_deg_q20(STEP));

  logic signed [DW-1:0]          dx, dy, cx_d, cy_d, cx_q, cy_q;
  logic signed [c2p_pkg::ZW-1:0] z_d, z_q;
  c2p_pkg::side_t                side_q;
  logic [COORD_WIDTH-1:0]        mag_q;
  logic                          up, en, valid_q;

  // arithmetic shift gives floor rounding
  assign dx = cy_i >>> STEP;
  assign dy = cx_i >>> STEP;
  assign up = !cy_i[DW-1];

  assign cx_d = up ? (cx_i + dx) : (cx_i - dx);
  assign cy_d = up ? (cy_i - dy) : (cy_i + dy);
  assign z_d  = up ? (z_i + ATAN) : (z_i - ATAN);

  assign en = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      z_q    <= z_d;
      side_q <= side_i;
      mag_q  <= mag_i;
    end
  end

  assign ready_o = en;
  assign valid_o = valid_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;
  assign z_o     = z_q;
  assign side_o  = side_q;
  assign mag_o   = mag_q;

endmodule

// File: design/c2p_post.sv
// c2p_post: gain correction multiply stage and result stage
// uses c2p_pkg; the result register drives the output channel
module c2p_post #(
  parameter int COORD_WIDTH = 16,
  parameter int DW          = 35
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [DW-1:0]          cx_i,
  input  logic signed [c2p_pkg::ZW-1:0] z_i,
  input  c2p_pkg::side_t                side_i,
  input  logic [COORD_WIDTH-1:0]        mag_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [COORD_WIDTH-1:0]        radius_o,
  output logic [c2p_pkg::ANGLE_W-1:0]   angle_o,
  output c2p_pkg::region_e              region_o
);

  localparam int GF  = c2p_pkg::GAIN_FRAC;
  localparam int HW  = DW - GF;
  localparam int RSW = DW + 1 - c2p_pkg::GUARD;
  localparam logic [DW:0] R_HALF = (DW + 1)'(1) << (c2p_pkg::GUARD - 1);

  // multiply stage
  logic [DW-1:0]                 cx_pos;
  logic [HW-1:0]                 hi;
  logic [GF-1:0]                 lo;
  logic [DW-1:0]                 ph_d, ph_q;
  logic [2*GF-1:0]               pl_full;
  logic [GF-1:0]                 pl_q;
  logic [c2p_pkg::ZW-1:0]        z_pos, z_rnd;
  logic [c2p_pkg::ZW-c2p_pkg::Z_SHIFT-1:0] a_full;
  logic [c2p_pkg::AMAG_W-1:0]    a_d, a_q;
  c2p_pkg::side_t                side_q;
  logic [COORD_WIDTH-1:0]        mag_q;
  logic                          en_m, valid_m_q;

  // result stage
  logic [DW:0]                   r_sum;
  logic [RSW-1:0]                r_scaled;
  logic [COORD_WIDTH-1:0]        rad_d, rad_q;
  logic [c2p_pkg::ANGLE_W-1:0]   a16, ang_d, ang_q;
  c2p_pkg::region_e              reg_q;
  logic                          en_o, valid_o_q;

  assign cx_pos  = cx_i[DW-1] ? '0 : cx_i;
  assign hi      = cx_pos[DW-1:GF];
  assign lo      = cx_pos[GF-1:0];
  assign ph_d    = DW'(hi) * DW'(c2p_pkg::INV_GAIN);
  assign pl_full = (2*GF)'(lo) * (2*GF)'(c2p_pkg::INV_GAIN);

  assign z_pos  = z_i[c2p_pkg::ZW-1] ? '0 : z_i;
  assign z_rnd  = z_pos + c2p_pkg::Z_ROUND;
  assign a_full = z_rnd[c2p_pkg::ZW-1:c2p_pkg::Z_SHIFT];
  assign a_d    = (c2p_pkg::ANGLE_W'(a_full) > c2p_pkg::DEG90) ?
                  c2p_pkg::AMAG_W'(c2p_pkg::DEG90) : a_full[c2p_pkg::AMAG_W-1:0];

  assign en_m = !valid_m_q || en_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
    end else if (en_m) begin
      valid_m_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m && valid_i) begin
      ph_q   <= ph_d;
      pl_q   <= pl_full[2*GF-1:GF];
      a_q    <= a_d;
      side_q <= side_i;
      mag_q  <= mag_i;
    end
  end

  // radius rounding and saturation
  assign r_sum    = {1'b0, ph_q} + (DW + 1)'(pl_q) + R_HALF;
  assign r_scaled = r_sum[DW:c2p_pkg::GUARD];
  assign a16      = c2p_pkg::ANGLE_W'(a_q);

  always_comb begin
    rad_d = (|r_scaled[RSW-1:COORD_WIDTH]) ? '1 : r_scaled[COORD_WIDTH-1:0];
    ang_d = a16;
    case (side_q.region)
      c2p_pkg::REG_ORIGIN: begin
        rad_d = '0;
        ang_d = c2p_pkg::DEG0;
      end
      c2p_pkg::REG_Y_AXIS: begin
        rad_d = mag_q;
        ang_d = side_q.neg ? c2p_pkg::DEG270 : c2p_pkg::DEG90;
      end
      c2p_pkg::REG_X_AXIS: begin
        rad_d = mag_q;
        ang_d = side_q.neg ? c2p_pkg::DEG180 : c2p_pkg::DEG0;
      end
      c2p_pkg::REG_Q1: ang_d = a16;
      c2p_pkg::REG_Q2: ang_d = c2p_pkg::DEG180 - a16;
      c2p_pkg::REG_Q3: ang_d = c2p_pkg::DEG180 + a16;
      c2p_pkg::REG_Q4: begin
        // a full turn wraps to zero
        ang_d = (a_q == '0) ? c2p_pkg::DEG0 : (c2p_pkg::DEG360 - a16);
      end
      default: ang_d = a16;
    endcase
  end

  assign en_o = !valid_o_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o_q <= 1'b0;
    end else if (en_o) begin
      valid_o_q <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && valid_m_q) begin
      rad_q <= rad_d;
      ang_q <= ang_d;
      reg_q <= side_q.region;
    end
  end

  assign ready_o  = en_m;
  assign valid_o  = valid_o_q;
  assign radius_o = rad_q;
  assign angle_o  = ang_q;
  assign region_o = reg_q;

endmodule
